[hdl/rgtd_pkg.sv]
// Shared types, codes and constants for the RDS group text decoder.
// Used by the controller, the datapath, the RAM and the top level.
package rgtd_pkg;

    // store sizes
    localparam int PS_CHARS = 8;
    localparam int RT_CHARS = 64;
    localparam int PS_AW    = $clog2(PS_CHARS);
    localparam int RT_AW    = $clog2(RT_CHARS);
    localparam int CHAR_W   = 8;

    // stream word widths
    localparam int IN_W     = 80;
    localparam int OUT_W    = 64;
    localparam int CMD_W    = 2;
    localparam int KIND_W   = 2;
    localparam int SLOT_W   = 2;

    // read index ranges: PS below RT_READ_BASE, RT below RT_READ_END
    localparam logic [6:0] RT_READ_BASE = 7'd8;
    localparam logic [6:0] RT_READ_END  = 7'd72;

    // character and field codes
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [1:0] GRADE_BAD = 2'd3;
    localparam logic [3:0] GROUP_PS  = 4'd0;
    localparam logic [3:0] GROUP_RT  = 4'd2;

    typedef enum logic [CMD_W-1:0] {
        CMD_DECODE = 2'd0,
        CMD_CLEAR  = 2'd1,
        CMD_READ   = 2'd2,
        CMD_NOP    = 2'd3
    } t_cmd;

    typedef enum logic [KIND_W-1:0] {
        KIND_NONE = 2'd0,
        KIND_PS   = 2'd1,
        KIND_RT   = 2'd2
    } t_kind;

    // controller to datapath
    typedef struct packed {
        logic              accept;
        logic              emit;
        logic [SLOT_W-1:0] slot;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic              out_free;
        logic [SLOT_W-1:0] last_slot;
    } t_dp_stat;

    // keep CR, turn other control codes into a space
    function automatic logic [7:0] map_char(input logic [7:0] c);
        logic [7:0] r;
        r = ((c < CH_SPACE) && (c != CH_CR)) ? CH_SPACE : c;
        return r;
    endfunction

endpackage

[hdl/rgtd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Depends on rgtd_pkg for default sizes.
module rgtd_ram #(
    parameter int WIDTH = rgtd_pkg::CHAR_W,
    parameter int DEPTH = rgtd_pkg::RT_CHARS
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port, holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[hdl/rgtd_ctrl.sv]
// Controller FSM: accepts one group word, then steps through its result slots.
// Depends on rgtd_pkg for the command and status structs.
module rgtd_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  rgtd_pkg::t_dp_stat i_stat,
    output rgtd_pkg::t_dp_cmd  o_cmd
);
    import rgtd_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } t_state;

    t_state            r_state, n_state;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic              w_accept, w_emit;

    assign o_s_tready = (r_state == ST_IDLE);
    assign w_accept   = i_s_tvalid && (r_state == ST_IDLE);
    assign w_emit     = (r_state == ST_EMIT) && i_stat.out_free;

    assign o_cmd.accept = w_accept;
    assign o_cmd.emit   = w_emit;
    assign o_cmd.slot   = r_slot;

    // next state
    always_comb begin
        n_state = r_state;
        n_slot  = r_slot;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_EMIT;
                    n_slot  = '0;
                end
            end
            ST_EMIT: begin
                if (w_emit) begin
                    if (r_slot == i_stat.last_slot) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_slot = r_slot + 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_slot  <= '0;
        end else begin
            r_state <= n_state;
            r_slot  <= n_slot;
        end
    end

    // a result is only produced into a free output register
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |-> i_stat.out_free)
        else $error("emit while output register busy");

    // every accepted word starts at slot zero
    a_start_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_EMIT) && (r_slot == '0))
        else $error("accept did not start emit at slot zero");

    // slot never runs past the last result of the word
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_slot <= i_stat.last_slot))
        else $error("slot beyond last result");
endmodule

[hdl/rgtd_dp.sv]
// Datapath: PI/PTY/mask state, PS and RadioText RAMs, and the output register.
// Depends on rgtd_pkg and rgtd_ram.
module rgtd_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  rgtd_pkg::t_dp_cmd           i_cmd,
    output rgtd_pkg::t_dp_stat          o_stat,
    input  logic [rgtd_pkg::IN_W-1:0]   i_s_tdata,
    input  logic [rgtd_pkg::CMD_W-1:0]  i_s_tuser,
    input  logic                        i_m_tready,
    output logic                        o_m_tvalid,
    output logic [rgtd_pkg::OUT_W-1:0]  o_m_tdata,
    output logic [rgtd_pkg::KIND_W-1:0] o_m_tuser,
    output logic                        o_m_tlast
);
    import rgtd_pkg::*;

    // unpacked input word
    logic [15:0] w_a, w_b, w_c, w_d;
    logic [7:0]  w_g;
    logic [6:0]  w_idx;
    t_cmd        w_op;
    logic        w_aok, w_bok, w_cok, w_dok;
    logic [3:0]  w_type, w_seg;
    logic        w_verb, w_ab;
    logic        w_ps_wr, w_rt_wr, w_restart;
    logic [RT_AW-1:0] w_rp;
    logic [3:0]  w_rseg;
    logic        w_rhit;

    // persistent decoder state
    logic [15:0]         r_pi;
    logic                r_pi_valid;
    logic [4:0]          r_pty;
    logic                r_pty_valid;
    logic [3:0]          r_ps_mask;
    logic [15:0]         r_rt_mask;
    logic [RT_CHARS-1:0] r_rt_valid;
    logic                r_ab_known, r_ab_last, r_vb_last;

    // current job
    t_kind              r_kind;
    logic [RT_AW-1:0]   r_base;
    logic [SLOT_W-1:0]  r_last_slot;
    logic [3:0][7:0]    r_chars;
    logic               r_wr, r_rd_rt, r_rd_ps, r_hit, r_restarted;

    // result path
    logic [RT_AW-1:0] w_pos;
    logic [7:0]       w_val, w_ram_q, w_ps_q;
    logic             w_ram_we, w_ram_re, w_ps_we, w_last;

    // output register
    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_data;
    t_kind            r_out_kind;
    logic             r_out_last;

    // field unpack, tdata lowest field first
    assign w_a   = i_s_tdata[15:0];
    assign w_b   = i_s_tdata[31:16];
    assign w_c   = i_s_tdata[47:32];
    assign w_d   = i_s_tdata[63:48];
    assign w_g   = i_s_tdata[71:64];
    assign w_idx = i_s_tdata[78:72];
    assign w_op  = t_cmd'(i_s_tuser);

    assign w_aok = (w_g[7:6] != GRADE_BAD);
    assign w_bok = (w_g[5:4] != GRADE_BAD);
    assign w_cok = (w_g[3:2] != GRADE_BAD);
    assign w_dok = (w_g[1:0] != GRADE_BAD);

    assign w_type = w_b[15:12];
    assign w_verb = w_b[11];
    assign w_ab   = w_b[4];
    assign w_seg  = w_b[3:0];

    // which store a decoded group writes, and whether text restarts
    assign w_ps_wr = (w_op == CMD_DECODE) && w_bok && (w_type == GROUP_PS) && w_dok;
    assign w_rt_wr = (w_op == CMD_DECODE) && w_bok && (w_type == GROUP_RT) && w_dok
                     && (w_verb || w_cok);
    assign w_restart = w_rt_wr && (!r_ab_known || (r_ab_last != w_ab)
                                   || (r_vb_last != w_verb));

    // read lookups: segment from position, stride set by last version
    assign w_rp         = w_idx[RT_AW-1:0] - RT_READ_BASE[RT_AW-1:0];
    assign w_rseg       = r_vb_last ? w_rp[4:1] : w_rp[5:2];
    assign w_rhit       = r_rt_mask[w_rseg] && r_rt_valid[w_rp];

    // latch the job for the accepted word
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_restarted <= w_restart;
            r_wr        <= w_ps_wr || w_rt_wr;
            r_rd_rt     <= 1'b0;
            r_rd_ps     <= 1'b0;
            r_hit       <= w_rhit;
            r_kind      <= KIND_NONE;
            r_base      <= '0;
            r_last_slot <= '0;
            r_chars     <= '0;
            unique case (w_op)
                CMD_DECODE: begin
                    if (w_ps_wr) begin
                        r_kind      <= KIND_PS;
                        r_base      <= {3'b000, w_seg[1:0], 1'b0};
                        r_last_slot <= 2'd1;
                        r_chars[0]  <= map_char(w_d[15:8]);
                        r_chars[1]  <= map_char(w_d[7:0]);
                    end else if (w_rt_wr) begin
                        r_kind <= KIND_RT;
                        if (w_verb) begin
                            r_base      <= {1'b0, w_seg, 1'b0};
                            r_last_slot <= 2'd1;
                            r_chars[0]  <= map_char(w_d[15:8]);
                            r_chars[1]  <= map_char(w_d[7:0]);
                        end else begin
                            r_base      <= {w_seg, 2'b00};
                            r_last_slot <= 2'd3;
                            r_chars[0]  <= map_char(w_c[15:8]);
                            r_chars[1]  <= map_char(w_c[7:0]);
                            r_chars[2]  <= map_char(w_d[15:8]);
                            r_chars[3]  <= map_char(w_d[7:0]);
                        end
                    end
                end
                CMD_READ: begin
                    if (w_idx < RT_READ_BASE) begin
                        r_kind  <= KIND_PS;
                        r_base  <= {3'b000, w_idx[PS_AW-1:0]};
                        r_rd_ps <= 1'b1;
                        r_hit   <= r_ps_mask[w_idx[2:1]];
                    end else if (w_idx < RT_READ_END) begin
                        r_kind  <= KIND_RT;
                        r_base  <= w_rp;
                        r_rd_rt <= 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // result slot: position, character and end flag
    assign w_pos    = r_base | {{(RT_AW-SLOT_W){1'b0}}, i_cmd.slot};
    assign w_val    = r_rd_rt ? (r_hit ? w_ram_q : CH_SPACE)
                    : r_rd_ps ? (r_hit ? w_ps_q : CH_SPACE)
                    : r_chars[i_cmd.slot];
    assign w_last   = (i_cmd.slot == r_last_slot);
    assign w_ram_we = i_cmd.emit && r_wr && (r_kind == KIND_RT);
    assign w_ps_we  = i_cmd.emit && r_wr && (r_kind == KIND_PS);
    assign w_ram_re = i_cmd.accept && (w_op == CMD_READ);

    // RadioText characters
    rgtd_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (RT_CHARS)
    ) u_rt_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_pos),
        .i_wdata (w_val),
        .i_re    (w_ram_re),
        .i_raddr (w_rp),
        .o_rdata (w_ram_q)
    );

    // PS characters, read only through the received mask
    rgtd_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (PS_CHARS)
    ) u_ps_ram (
        .i_clk   (i_clk),
        .i_we    (w_ps_we),
        .i_waddr (w_pos[PS_AW-1:0]),
        .i_wdata (w_val),
        .i_re    (w_ram_re),
        .i_raddr (w_idx[PS_AW-1:0]),
        .o_rdata (w_ps_q)
    );

    // PI, PTY, masks and text version state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pi        <= '0;
            r_pi_valid  <= 1'b0;
            r_pty       <= '0;
            r_pty_valid <= 1'b0;
            r_ps_mask   <= '0;
            r_rt_mask   <= '0;
            r_rt_valid  <= '0;
            r_ab_known  <= 1'b0;
            r_ab_last   <= 1'b0;
            r_vb_last   <= 1'b0;
        end else begin
            if (i_cmd.accept && (w_op == CMD_CLEAR)) begin
                r_pi        <= '0;
                r_pi_valid  <= 1'b0;
                r_pty       <= '0;
                r_pty_valid <= 1'b0;
                r_ps_mask   <= '0;
                r_rt_mask   <= '0;
                r_rt_valid  <= '0;
                r_ab_known  <= 1'b0;
                r_ab_last   <= 1'b0;
                r_vb_last   <= 1'b0;
            end else if (i_cmd.accept && (w_op == CMD_DECODE)) begin
                if (w_aok) begin
                    r_pi       <= w_a;
                    r_pi_valid <= 1'b1;
                end
                if (w_bok) begin
                    r_pty       <= w_b[9:5];
                    r_pty_valid <= 1'b1;
                end
                if (w_ps_wr) begin
                    r_ps_mask <= r_ps_mask | (4'b0001 << w_seg[1:0]);
                end
                if (w_rt_wr) begin
                    if (w_restart) begin
                        r_rt_mask  <= 16'h0001 << w_seg;
                        r_rt_valid <= '0;
                        r_ab_known <= 1'b1;
                        r_ab_last  <= w_ab;
                        r_vb_last  <= w_verb;
                    end else begin
                        r_rt_mask <= r_rt_mask | (16'h0001 << w_seg);
                    end
                end
            end
            if (w_ram_we) begin
                r_rt_valid[w_pos] <= 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_data <= {6'b000000, r_rt_mask, r_ps_mask, r_restarted, w_val, w_pos,
                           r_pty_valid, r_pty, r_pi_valid, r_pi};
            r_out_kind <= r_kind;
            r_out_last <= w_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_kind;
    assign o_m_tlast  = r_out_last;

    assign o_stat.out_free  = !r_out_valid || i_m_tready;
    assign o_stat.last_slot = r_last_slot;

    // clear returns all masks and flags to reset
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.accept && (w_op == CMD_CLEAR)) |=>
            (r_rt_mask == '0) && (r_ps_mask == '0) && (r_rt_valid == '0) && !r_pi_valid)
        else $error("clear left state behind");

    // a RadioText write always belongs to a received segment
    a_rt_write_seg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ram_we |-> (r_rt_mask != '0) && r_ab_known)
        else $error("RadioText write without segment mask");

    // a stalled result word holds until it is taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_tready) |=>
            r_out_valid && $stable(r_out_data) && $stable(r_out_last))
        else $error("result word changed while stalled");
endmodule

[hdl/rds_group_text_decoder.sv]
// RDS group text decoder: one word in, one to four result words out, in order.
// After a word is accepted the controller enters its emit state and loads each result word
// into the output register. N results per input word: 4 for version A RadioText groups,
// 2 for PS and version B groups, 1 otherwise; one result per cycle while the sink is ready.
// Reset: synchronous active low; clears PI, PTY, masks and text state, no RAM sweep.
module rds_group_text_decoder (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // block_a, block_b, block_c, block_d, error_grades, read_index, pad
    input  logic [rgtd_pkg::IN_W-1:0]   s_axis_tdata,
    // command
    input  logic [rgtd_pkg::CMD_W-1:0]  s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // pi_code, pi_known, pty_code, pty_known, char_position, char_value,
    // text_restarted, ps_segments, rt_segments, pad
    output logic [rgtd_pkg::OUT_W-1:0]  m_axis_tdata,
    // text_kind
    output logic [rgtd_pkg::KIND_W-1:0] m_axis_tuser,
    output logic                        m_axis_tlast
);
    import rgtd_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    rgtd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    rgtd_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .i_s_tdata  (s_axis_tdata),
        .i_s_tuser  (s_axis_tuser),
        .i_m_tready (m_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .o_m_tdata  (m_axis_tdata),
        .o_m_tuser  (m_axis_tuser),
        .o_m_tlast  (m_axis_tlast)
    );
endmodule

[bench/tb_top.sv]
// Self-checking bench for rds_group_text_decoder: queued stimulus, clocked driver and
// monitor, and an in-bench decoder that predicts every result word in order.
// Depends on rgtd_pkg (hdl/rgtd_pkg.sv) and the decoder RTL.
module tb_top;
    import rgtd_pkg::*;

    localparam int RUN_LIMIT   = 300000;
    localparam int RANDOM_CNT  = 225;
    localparam int REPORT_CAP  = 40;
    localparam int TAIL_CYCLES = 12;

    // one input word as the sender sees it
    typedef struct {
        t_cmd        cmd;
        logic [15:0] blk_a;
        logic [15:0] blk_b;
        logic [15:0] blk_c;
        logic [15:0] blk_d;
        logic [7:0]  grades;
        logic [6:0]  index;
        bit          drain;
    } t_group_item;

    // one result word, field by field
    typedef struct {
        logic [15:0] pi;
        logic        pi_ok;
        logic [4:0]  pty;
        logic        pty_ok;
        t_kind       kind;
        logic [5:0]  pos;
        logic [7:0]  ch;
        logic        restarted;
        logic [3:0]  ps_seg;
        logic [15:0] rt_seg;
        logic        is_last;
    } t_text_word;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [IN_W-1:0]    s_axis_tdata = '0;
    logic [CMD_W-1:0]   s_axis_tuser = '0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [OUT_W-1:0]   m_axis_tdata;
    logic [KIND_W-1:0]  m_axis_tuser;
    logic               m_axis_tlast;

    rds_group_text_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #1 i_clk = ~i_clk;

    // stimulus and expected words
    t_group_item group_queue[$];
    t_text_word  due_words[$];

    // predicted decoder state
    logic [15:0] pi_q;
    logic        pi_ok;
    logic [4:0]  pty_q;
    logic        pty_ok;
    logic [7:0]  ps_chars[PS_CHARS];
    logic [7:0]  rt_chars[RT_CHARS];
    logic [3:0]  ps_seen;
    logic [15:0] rt_seen;
    logic        ab_seen;
    logic        ab_flag;
    logic        ver_b;

    // bookkeeping
    int          errors = 0;
    int          cycles = 0;
    int          n_decode = 0;
    int          n_read = 0;
    int          n_clear = 0;
    int          n_other = 0;
    int          n_words = 0;
    int          n_restarts = 0;
    logic        rt_ab_cur = 1'b0;
    logic        rt_ver_cur = 1'b0;

    // stretches with no idling on either side
    function automatic int draw_wait();
        return ((cycles % 3000) < 700) ? 0 : int'($urandom_range(0, 12));
    endfunction

    // keep CR, other control codes shown as space
    function automatic logic [7:0] shown_char(input logic [7:0] c);
        if (c == CH_CR) return c;
        if (c < CH_SPACE) return CH_SPACE;
        return c;
    endfunction

    function automatic void clear_text_state();
        pi_q = '0;
        pi_ok = 1'b0;
        pty_q = '0;
        pty_ok = 1'b0;
        foreach (ps_chars[i]) ps_chars[i] = CH_SPACE;
        foreach (rt_chars[i]) rt_chars[i] = CH_SPACE;
        ps_seen = '0;
        rt_seen = '0;
        ab_seen = 1'b0;
        ab_flag = 1'b0;
        ver_b = 1'b0;
    endfunction

    // expected word built from the current predicted state
    function automatic void push_word(input t_kind k, input logic [5:0] pos,
                                      input logic [7:0] ch, input logic rs,
                                      input logic lst);
        t_text_word w;
        w.pi = pi_q;
        w.pi_ok = pi_ok;
        w.pty = pty_q;
        w.pty_ok = pty_ok;
        w.kind = k;
        w.pos = pos;
        w.ch = ch;
        w.restarted = rs;
        w.ps_seg = ps_seen;
        w.rt_seg = rt_seen;
        w.is_last = lst;
        due_words.push_back(w);
    endfunction

    // apply one accepted word to the predicted decoder, queue its result words
    function automatic void advance_decoder(input t_group_item it);
        logic [1:0] ga, gb, gc, gd;
        logic       verb, rs;
        logic [3:0] seg;
        logic [5:0] p;
        logic [3:0] rseg;
        logic [7:0] ch;
        int         base, n;
        ga = it.grades[7:6];
        gb = it.grades[5:4];
        gc = it.grades[3:2];
        gd = it.grades[1:0];
        rs = 1'b0;
        n = 0;
        case (it.cmd)
            CMD_DECODE: begin
                if (ga != GRADE_BAD) begin
                    pi_q = it.blk_a;
                    pi_ok = 1'b1;
                end
                if (gb != GRADE_BAD) begin
                    verb = it.blk_b[11];
                    pty_q = it.blk_b[9:5];
                    pty_ok = 1'b1;
                    if (it.blk_b[15:12] == GROUP_PS && gd != GRADE_BAD) begin
                        base = int'(it.blk_b[1:0]) * 2;
                        ps_chars[base] = shown_char(it.blk_d[15:8]);
                        ps_chars[base + 1] = shown_char(it.blk_d[7:0]);
                        ps_seen[it.blk_b[1:0]] = 1'b1;
                        push_word(KIND_PS, 6'(base), ps_chars[base], 1'b0, 1'b0);
                        push_word(KIND_PS, 6'(base + 1), ps_chars[base + 1], 1'b0, 1'b1);
                        n = 2;
                    end else if (it.blk_b[15:12] == GROUP_RT && gd != GRADE_BAD &&
                                 (verb || gc != GRADE_BAD)) begin
                        seg = it.blk_b[3:0];
                        // A/B flag or version change, or first text group: restart
                        if (!ab_seen || ab_flag != it.blk_b[4] || ver_b != verb) begin
                            foreach (rt_chars[i]) rt_chars[i] = CH_SPACE;
                            rt_seen = '0;
                            ab_seen = 1'b1;
                            ab_flag = it.blk_b[4];
                            ver_b = verb;
                            rs = 1'b1;
                        end
                        if (verb) begin
                            base = int'(seg) * 2;
                            rt_chars[base] = shown_char(it.blk_d[15:8]);
                            rt_chars[base + 1] = shown_char(it.blk_d[7:0]);
                            n = 2;
                        end else begin
                            base = int'(seg) * 4;
                            rt_chars[base] = shown_char(it.blk_c[15:8]);
                            rt_chars[base + 1] = shown_char(it.blk_c[7:0]);
                            rt_chars[base + 2] = shown_char(it.blk_d[15:8]);
                            rt_chars[base + 3] = shown_char(it.blk_d[7:0]);
                            n = 4;
                        end
                        rt_seen[seg] = 1'b1;
                        for (int i = 0; i < n; i++)
                            push_word(KIND_RT, 6'(base + i), rt_chars[base + i], rs,
                                      i == n - 1);
                    end
                end
                if (rs) n_restarts++;
                if (n == 0) push_word(KIND_NONE, '0, '0, rs, 1'b1);
            end
            CMD_CLEAR: begin
                clear_text_state();
                push_word(KIND_NONE, '0, '0, 1'b0, 1'b1);
            end
            CMD_READ: begin
                if (it.index < RT_READ_BASE) begin
                    ch = ps_seen[it.index[2:1]] ? ps_chars[it.index[2:0]] : CH_SPACE;
                    push_word(KIND_PS, it.index[5:0], ch, 1'b0, 1'b1);
                end else if (it.index < RT_READ_END) begin
                    p = 6'(it.index - RT_READ_BASE);
                    rseg = ver_b ? p[4:1] : p[5:2];
                    ch = rt_seen[rseg] ? rt_chars[p] : CH_SPACE;
                    push_word(KIND_RT, p, ch, 1'b0, 1'b1);
                end else begin
                    push_word(KIND_NONE, '0, '0, 1'b0, 1'b1);
                end
            end
            default: push_word(KIND_NONE, '0, '0, 1'b0, 1'b1);
        endcase
    endfunction

    function automatic logic [15:0] rds_b(input logic [3:0] gtype, input logic verb,
                                          input logic [4:0] pty, input logic ab,
                                          input logic [3:0] seg);
        return {gtype, verb, 1'b0, pty, ab, seg};
    endfunction

    function automatic void queue_item(input t_cmd cmd, input logic [15:0] a,
                                       input logic [15:0] b, input logic [15:0] c,
                                       input logic [15:0] d, input logic [7:0] g,
                                       input logic [6:0] idx, input bit drain);
        t_group_item it;
        it.cmd = cmd;
        it.blk_a = a;
        it.blk_b = b;
        it.blk_c = c;
        it.blk_d = d;
        it.grades = g;
        it.index = idx;
        it.drain = drain;
        group_queue.push_back(it);
    endfunction

    // usable grades most of the time, now and then one block marked bad
    function automatic logic [7:0] draw_grades();
        logic [7:0] g;
        g = {2'($urandom_range(0, 2)), 2'($urandom_range(0, 2)),
             2'($urandom_range(0, 2)), 2'($urandom_range(0, 2))};
        if ($urandom_range(0, 6) == 0) g[2 * $urandom_range(0, 3) +: 2] = GRADE_BAD;
        return g;
    endfunction

    // random word: mostly well-formed text groups, some reads, some noise
    function automatic void queue_random(input bit drain);
        int         r;
        logic [3:0] gtype;
        logic [6:0] idx;
        r = $urandom_range(0, 99);
        if (r < 30) begin
            if ($urandom_range(0, 11) == 0) rt_ab_cur = ~rt_ab_cur;
            if ($urandom_range(0, 19) == 0) rt_ver_cur = ~rt_ver_cur;
            queue_item(CMD_DECODE, 16'($urandom), rds_b(GROUP_RT, rt_ver_cur,
                       5'($urandom), rt_ab_cur, 4'($urandom)), 16'($urandom),
                       16'($urandom), draw_grades(), 7'($urandom), drain);
        end else if (r < 50) begin
            queue_item(CMD_DECODE, 16'($urandom),
                       rds_b(GROUP_PS, 1'($urandom), 5'($urandom), 1'($urandom),
                             4'($urandom)), 16'($urandom), 16'($urandom),
                       draw_grades(), 7'($urandom), drain);
        end else if (r < 75) begin
            idx = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(72, 127))
                                               : 7'($urandom_range(0, 71));
            queue_item(CMD_READ, 16'($urandom), 16'($urandom), 16'($urandom),
                       16'($urandom), 8'($urandom), idx, drain);
        end else if (r < 85) begin
            queue_item(CMD_DECODE, 16'($urandom), 16'($urandom), 16'($urandom),
                       16'($urandom), 8'($urandom), 7'($urandom), drain);
        end else if (r < 90) begin
            do gtype = 4'($urandom); while (gtype == GROUP_PS || gtype == GROUP_RT);
            queue_item(CMD_DECODE, 16'($urandom),
                       rds_b(gtype, 1'($urandom), 5'($urandom), 1'($urandom),
                             4'($urandom)), 16'($urandom), 16'($urandom),
                       draw_grades(), 7'($urandom), drain);
        end else if (r < 94) begin
            queue_item(CMD_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom),
                       16'($urandom), 8'($urandom), 7'($urandom), drain);
        end else if (r < 97) begin
            queue_item(CMD_NOP, 16'($urandom), 16'($urandom), 16'($urandom),
                       16'($urandom), 8'($urandom), 7'($urandom), drain);
        end else begin
            queue_item(t_cmd'($urandom_range(0, 3)), 16'($urandom), 16'($urandom),
                       16'($urandom), 16'($urandom), 8'($urandom), 7'($urandom), drain);
        end
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            errors++;
            if (errors <= REPORT_CAP)
                $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        end
    endfunction

    // sender: one word at a time, random gap after each accepted word
    t_group_item tx_cur;
    int          tx_gap = 0;

    always @(posedge i_clk) begin : tx_side
        logic nv;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            tx_gap = 0;
        end else begin
            nv = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready) begin
                advance_decoder(tx_cur);
                case (tx_cur.cmd)
                    CMD_DECODE: n_decode++;
                    CMD_READ:   n_read++;
                    CMD_CLEAR:  n_clear++;
                    default:    n_other++;
                endcase
                nv = 1'b0;
                tx_gap = draw_wait();
            end
            if (!nv) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (group_queue.size() != 0 &&
                             !(group_queue[0].drain && due_words.size() != 0)) begin
                    tx_cur = group_queue.pop_front();
                    s_axis_tdata <= {1'b0, tx_cur.index, tx_cur.grades, tx_cur.blk_d,
                                     tx_cur.blk_c, tx_cur.blk_b, tx_cur.blk_a};
                    s_axis_tuser <= tx_cur.cmd;
                    nv = 1'b1;
                end
            end
            s_axis_tvalid <= nv;
        end
    end

    // receiver: check each word against the oldest expectation, then stall at random
    int rx_stall = 0;

    always @(posedge i_clk) begin : rx_side
        logic       nr;
        t_text_word w;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_stall = 0;
        end else begin
            nr = m_axis_tready;
            if (m_axis_tvalid && m_axis_tready) begin
                n_words++;
                if (due_words.size() == 0) begin
                    errors++;
                    if (errors <= REPORT_CAP)
                        $display("%0t: extra word, expected none actual %h/%h/%b",
                                 $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                end else begin
                    w = due_words.pop_front();
                    check_field("pi_code", w.pi, m_axis_tdata[15:0]);
                    check_field("pi_known", w.pi_ok, m_axis_tdata[16]);
                    check_field("pty_code", w.pty, m_axis_tdata[21:17]);
                    check_field("pty_known", w.pty_ok, m_axis_tdata[22]);
                    check_field("text_kind", w.kind, m_axis_tuser);
                    check_field("char_position", w.pos, m_axis_tdata[28:23]);
                    check_field("char_value", w.ch, m_axis_tdata[36:29]);
                    check_field("text_restarted", w.restarted, m_axis_tdata[37]);
                    check_field("ps_segments", w.ps_seg, m_axis_tdata[41:38]);
                    check_field("rt_segments", w.rt_seg, m_axis_tdata[57:42]);
                    check_field("last", w.is_last, m_axis_tlast);
                end
                rx_stall = draw_wait();
                nr = 1'b0;
            end
            if (!nr) begin
                if (rx_stall > 0) rx_stall--;
                else nr = 1'b1;
            end
            m_axis_tready <= nr;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= RUN_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still expected", cycles,
                     due_words.size());
            $display("tb_top: errors");
            $finish;
        end
    end

    initial begin
        clear_text_state();

        // directed: empty reads, PS and text extremes, restarts, bad grades
        queue_item(CMD_READ, '0, '0, '0, '0, '0, 7'd0, 1'b0);
        queue_item(CMD_READ, '0, '0, '0, '0, '0, 7'd8, 1'b0);
        queue_item(CMD_DECODE, 16'hFFFF, rds_b(GROUP_PS, 1'b0, 5'd31, 1'b0, 4'd0),
                   16'h0000, 16'h4142, 8'h00, 7'd0, 1'b0);
        queue_item(CMD_DECODE, 16'h0000, rds_b(GROUP_PS, 1'b1, 5'd5, 1'b1, 4'hF),
                   16'hFFFF, 16'h0D1F, 8'hAA, 7'd0, 1'b0);
        queue_item(CMD_DECODE, 16'h1234, rds_b(GROUP_RT, 1'b0, 5'd0, 1'b0, 4'd0),
                   16'h0000, 16'hFFFF, 8'h00, 7'd0, 1'b0);
        queue_item(CMD_DECODE, 16'h1234, rds_b(GROUP_RT, 1'b0, 5'd10, 1'b0, 4'hF),
                   16'h7F80, 16'h0D0A, 8'h00, 7'd0, 1'b0);
        queue_item(CMD_READ, '0, '0, '0, '0, '0, 7'd8, 1'b0);
        queue_item(CMD_READ, '0, '0, '0, '0, '0, 7'd71, 1'b0);
        queue_item(CMD_READ, '0, '0, '0, '0, '0, 7'd3, 1'b0);
        queue_item(CMD_READ, '0, '0, '0, '0, '0, 7'd6, 1'b0);
        queue_item(CMD_DECODE, 16'h1234, rds_b(GROUP_RT, 1'b0, 5'd10, 1'b1, 4'd3),
                   16'h5A5A, 16'h3031, 8'h00, 7'd0, 1'b0);
        queue_item(CMD_DECODE, 16'h4321, rds_b(GROUP_RT, 1'b1, 5'd10, 1'b1, 4'hF),
                   16'hFFFF, 16'h2021, 8'h0C, 7'd0, 1'b0);
        queue_item(CMD_READ, '0, '0, '0, '0, '0, 7'd71, 1'b0);
        queue_item(CMD_READ, '0, '0, '0, '0, '0, 7'd39, 1'b0);
        queue_item(CMD_DECODE, 16'hBEEF, rds_b(GROUP_RT, 1'b1, 5'd3, 1'b0, 4'd1),
                   16'h0000, 16'h4142, 8'hF0, 7'd0, 1'b0);
        queue_item(CMD_DECODE, 16'hCAFE, rds_b(4'd5, 1'b0, 5'd7, 1'b0, 4'd2),
                   16'h4142, 16'h4344, 8'h00, 7'd0, 1'b0);
        queue_item(CMD_DECODE, 16'hCAFE, rds_b(GROUP_RT, 1'b0, 5'd7, 1'b0, 4'd2),
                   16'h4142, 16'h4344, 8'h0C, 7'd0, 1'b0);
        queue_item(CMD_DECODE, 16'hCAFE, rds_b(GROUP_PS, 1'b0, 5'd7, 1'b0, 4'd2),
                   16'h4142, 16'h4344, 8'h03, 7'd0, 1'b0);
        queue_item(CMD_NOP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 7'h7F, 1'b0);
        queue_item(CMD_READ, '0, '0, '0, '0, '0, 7'd72, 1'b0);
        queue_item(CMD_READ, '0, '0, '0, '0, '0, 7'd127, 1'b0);
        queue_item(CMD_CLEAR, '0, '0, '0, '0, '0, 7'd0, 1'b1);
        queue_item(CMD_READ, '0, '0, '0, '0, '0, 7'd0, 1'b0);
        queue_item(CMD_READ, '0, '0, '0, '0, '0, 7'd8, 1'b0);
        queue_item(CMD_DECODE, 16'h0001, rds_b(GROUP_RT, 1'b1, 5'd1, 1'b0, 4'd0),
                   16'h0000, 16'h6162, 8'h00, 7'd0, 1'b0);

        // random: the sender drains the decoder now and then
        for (int i = 0; i < RANDOM_CNT; i++)
            queue_random(i % 50 == 25);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (group_queue.size() != 0 || s_axis_tvalid || due_words.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (due_words.size() != 0) errors++;
        $display("run: %0d decode, %0d read, %0d clear, %0d other commands; %0d words",
                 n_decode, n_read, n_clear, n_other, n_words);
        $display("run: %0d text restarts, %0d cycles, %0d mismatches", n_restarts,
                 cycles, errors);
        if (errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
